/* design/fsp_pkg.sv */
// ----------------------------------------------------------------------------
// fsp_pkg
// Shared types and constants of the conversion specification parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fsp_pkg;

  // Default sizing of the accumulators and of the length modifier count.
  localparam int NUM_BITS_DEF   = 16;
  localparam int MAX_LENGTH_DEF = 2;

  // Fixed field widths of the channels.
  localparam int CHAR_W  = 8;
  localparam int FIELD_W = 16;
  localparam int LEN_W   = 2;
  localparam int DIGIT_W = 4;

  // Flag positions inside the flag vector.
  localparam int FLAG_LEFT  = 0;
  localparam int FLAG_ZERO  = 1;
  localparam int FLAG_ALT   = 2;
  localparam int FLAG_SPACE = 3;
  localparam int FLAG_PLUS  = 4;
  localparam int FLAG_COUNT = 5;

  // Character codes the parser recognizes.
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_ELL   = 8'h6C;

  // Parser phase.
  typedef enum logic [1:0] {
    PH_FLAG  = 2'd0,
    PH_WIDTH = 2'd1,
    PH_PREC  = 2'd2,
    PH_LEN   = 2'd3
  } phase_t;

  // Classification of one input character.
  typedef struct packed {
    logic                  is_digit;
    logic [DIGIT_W-1:0]    digit;
    logic                  is_flag;
    logic [FLAG_COUNT-1:0] flag_onehot;
    logic                  is_dot;
    logic                  is_ell;
  } char_class_t;

  // One decoded specification.
  typedef struct packed {
    logic [FLAG_COUNT-1:0] flags;
    logic                  width_given;
    logic [FIELD_W-1:0]    width_value;
    logic                  prec_given;
    logic [FIELD_W-1:0]    prec_value;
    logic [LEN_W-1:0]      length_count;
    logic [CHAR_W-1:0]     type_char;
  } spec_t;

endpackage

`default_nettype wire

/* design/fsp_in_stage.sv */
// ----------------------------------------------------------------------------
// fsp_in_stage
// Input register of the parser: holds one character until the core takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fsp_in_stage (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [fsp_pkg::CHAR_W-1:0] in_char_in,
  input  wire logic                      advance,
  output logic                           hold_valid,
  output logic [fsp_pkg::CHAR_W-1:0]     hold_char
);

  logic                       valid_r;
  logic                       valid_nxt;
  logic [fsp_pkg::CHAR_W-1:0] char_r;
  logic                       accept;

  // The register frees up whenever the core consumes the item it holds.
  assign in_stall = valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  // Valid bit with reset, character register without.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      char_r <= in_char_in;
    end
  end

  assign hold_valid = valid_r;
  assign hold_char  = char_r;

endmodule

`default_nettype wire

/* design/fsp_char_class.sv */
// ----------------------------------------------------------------------------
// fsp_char_class
// Character decoder: digit, flag, dot and length modifier detection.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fsp_char_class (
  input  wire logic [fsp_pkg::CHAR_W-1:0] char_in,
  output fsp_pkg::char_class_t            cls
);

  // Decode all classes in parallel; the core picks by phase.
  always_comb begin
    cls.is_digit = (char_in >= fsp_pkg::CH_ZERO) && (char_in <= fsp_pkg::CH_NINE);
    cls.digit    = char_in[fsp_pkg::DIGIT_W-1:0];
    cls.flag_onehot[fsp_pkg::FLAG_LEFT]  = (char_in == fsp_pkg::CH_MINUS);
    cls.flag_onehot[fsp_pkg::FLAG_ZERO]  = (char_in == fsp_pkg::CH_ZERO);
    cls.flag_onehot[fsp_pkg::FLAG_ALT]   = (char_in == fsp_pkg::CH_HASH);
    cls.flag_onehot[fsp_pkg::FLAG_SPACE] = (char_in == fsp_pkg::CH_SPACE);
    cls.flag_onehot[fsp_pkg::FLAG_PLUS]  = (char_in == fsp_pkg::CH_PLUS);
    cls.is_flag  = |cls.flag_onehot;
    cls.is_dot   = (char_in == fsp_pkg::CH_DOT);
    cls.is_ell   = (char_in == fsp_pkg::CH_ELL);
  end

endmodule

`default_nettype wire

/* design/fsp_parse_core.sv */
// ----------------------------------------------------------------------------
// fsp_parse_core
// Parser state, saturating decimal accumulator and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fsp_parse_core #(
  parameter int NUM_BITS   = fsp_pkg::NUM_BITS_DEF,
  parameter int MAX_LENGTH = fsp_pkg::MAX_LENGTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       hold_valid,
  input  wire logic [fsp_pkg::CHAR_W-1:0] hold_char,
  input  fsp_pkg::char_class_t            cls,
  output logic                            advance,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output fsp_pkg::spec_t                  out_spec
);

  localparam int EXT_W = (NUM_BITS > fsp_pkg::FIELD_W) ? NUM_BITS : fsp_pkg::FIELD_W;
  localparam logic [fsp_pkg::LEN_W-1:0] LEN_MAX = fsp_pkg::LEN_W'(MAX_LENGTH);

  fsp_pkg::phase_t                phase_r, phase_nxt;
  logic [fsp_pkg::FLAG_COUNT-1:0] flags_r, flags_nxt;
  logic [NUM_BITS-1:0]            width_r, width_nxt;
  logic                           width_seen_r, width_seen_nxt;
  logic [NUM_BITS-1:0]            prec_r, prec_nxt;
  logic                           prec_seen_r, prec_seen_nxt;
  logic [fsp_pkg::LEN_W-1:0]      len_r, len_nxt;
  logic                           out_valid_r, out_valid_nxt;
  fsp_pkg::spec_t                 spec_r;

  logic                fire;
  logic                emit;
  logic [NUM_BITS-1:0] acc_in;
  logic [NUM_BITS+3:0] acc_sum;
  logic [NUM_BITS-1:0] acc_out;
  logic [EXT_W-1:0]    width_ext;
  logic [EXT_W-1:0]    prec_ext;
  fsp_pkg::spec_t      spec_nxt;

  // The held item moves on whenever the result slot is free or being emptied.
  assign advance = !out_valid_r || !out_stall;
  assign fire    = hold_valid && advance;

  // One shared times-ten-plus-digit unit, saturating at the all-ones value.
  assign acc_in  = (phase_r == fsp_pkg::PH_PREC) ? prec_r : width_r;
  assign acc_sum = {acc_in, 3'b000} + {2'b00, acc_in, 1'b0}
                 + (NUM_BITS+4)'(cls.digit - fsp_pkg::DIGIT_W'(fsp_pkg::CH_ZERO));
  assign acc_out = (|acc_sum[NUM_BITS+3:NUM_BITS]) ? '1 : acc_sum[NUM_BITS-1:0];

  // Result fields carry the low bits of the accumulators.
  assign width_ext = EXT_W'(width_r);
  assign prec_ext  = EXT_W'(prec_r);

  always_comb begin
    spec_nxt.flags        = flags_r;
    spec_nxt.width_given  = width_seen_r;
    spec_nxt.width_value  = width_ext[fsp_pkg::FIELD_W-1:0];
    spec_nxt.prec_given   = prec_seen_r;
    spec_nxt.prec_value   = prec_ext[fsp_pkg::FIELD_W-1:0];
    spec_nxt.length_count = len_r;
    spec_nxt.type_char    = hold_char;
  end

  // Next state: the first rule that matches the phase and character wins.
  always_comb begin
    phase_nxt      = phase_r;
    flags_nxt      = flags_r;
    width_nxt      = width_r;
    width_seen_nxt = width_seen_r;
    prec_nxt       = prec_r;
    prec_seen_nxt  = prec_seen_r;
    len_nxt        = len_r;
    emit           = 1'b0;
    if (fire) begin
      if ((phase_r == fsp_pkg::PH_FLAG) && cls.is_flag) begin
        flags_nxt = flags_r | cls.flag_onehot;
      end else if (cls.is_digit && ((phase_r == fsp_pkg::PH_FLAG) ||
                                    (phase_r == fsp_pkg::PH_WIDTH))) begin
        width_nxt      = acc_out;
        width_seen_nxt = 1'b1;
        phase_nxt      = fsp_pkg::PH_WIDTH;
      end else if (cls.is_dot && ((phase_r == fsp_pkg::PH_FLAG) ||
                                  (phase_r == fsp_pkg::PH_WIDTH))) begin
        prec_seen_nxt = 1'b1;
        prec_nxt      = '0;
        phase_nxt     = fsp_pkg::PH_PREC;
      end else if (cls.is_digit && (phase_r == fsp_pkg::PH_PREC)) begin
        prec_nxt = acc_out;
      end else if (cls.is_ell && (len_r < LEN_MAX)) begin
        len_nxt   = len_r + fsp_pkg::LEN_W'(1);
        phase_nxt = fsp_pkg::PH_LEN;
      end else begin
        // Any other character closes the specification.
        emit           = 1'b1;
        phase_nxt      = fsp_pkg::PH_FLAG;
        flags_nxt      = '0;
        width_nxt      = '0;
        width_seen_nxt = 1'b0;
        prec_nxt       = '0;
        prec_seen_nxt  = 1'b0;
        len_nxt        = '0;
      end
    end
  end

  // The result slot fills on a closing character and drains when taken.
  always_comb begin
    if (fire && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= fsp_pkg::PH_FLAG;
      flags_r      <= '0;
      width_r      <= '0;
      width_seen_r <= 1'b0;
      prec_r       <= '0;
      prec_seen_r  <= 1'b0;
      len_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      flags_r      <= flags_nxt;
      width_r      <= width_nxt;
      width_seen_r <= width_seen_nxt;
      prec_r       <= prec_nxt;
      prec_seen_r  <= prec_seen_nxt;
      len_r        <= len_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (fire && emit) begin
      spec_r <= spec_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_spec  = spec_r;

  // A closing character leaves the parser back at its starting state.
  a_reset_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && emit) |=> (phase_r == fsp_pkg::PH_FLAG) && (flags_r == '0) &&
                       (len_r == '0) && !width_seen_r && !prec_seen_r)
    else $error("parser state not cleared after a closing character");

  // The length modifier count never passes its limit.
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_MAX)
    else $error("length modifier count above its limit");

  // The length phase is only reached through at least one modifier.
  a_len_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == fsp_pkg::PH_LEN) |-> (len_r != '0))
    else $error("length phase with no modifier counted");

  // A width value exists only once a width digit was seen.
  a_width_seen: assert property (@(posedge clk) disable iff (!rst_n)
    !width_seen_r |-> (width_r == '0))
    else $error("width accumulator set without a width digit");

  // The precision phase implies the dot was seen.
  a_prec_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == fsp_pkg::PH_PREC) |-> prec_seen_r)
    else $error("precision phase without a dot");

endmodule

`default_nettype wire

/* design/format_spec_parser_unit.sv */
// ----------------------------------------------------------------------------
// format_spec_parser_unit
// Decodes the characters after a percent sign into one conversion spec.
// ----------------------------------------------------------------------------
// The in_ channel takes one character per item; the out_ channel gives one
// item per completed specification, carrying flags, width, precision, length
// modifier count and the type character. A character is taken on a rising
// edge with valid high and stall low, on either channel.
// Flag, digit, dot and 'l' characters update the parser state where the phase
// and, for 'l', the modifier limit allow them; any other character closes the
// specification and yields one result item. Throughput is one character per
// cycle while no waiting result is stalled: the phase state and the shared
// times-ten accumulator close their loop without a further register. A closing
// character passes the input register and then loads the result register,
// which raises out_valid; the result can then be taken.
// While the receiver stalls a waiting result, the parser takes nothing from
// the input register; once that register holds an item, in_stall rises in
// the same cycle as out_stall and the item stays put until the result is
// taken.
// Synchronous reset clears the parser to the flag phase and empties both
// registers; no result is pending afterwards.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module format_spec_parser_unit #(
  parameter int NUM_BITS   = fsp_pkg::NUM_BITS_DEF,
  parameter int MAX_LENGTH = fsp_pkg::MAX_LENGTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [fsp_pkg::CHAR_W-1:0]   in_char_in,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              out_flag_left,
  output logic                              out_flag_zero,
  output logic                              out_flag_alt,
  output logic                              out_flag_space,
  output logic                              out_flag_plus,
  output logic                              out_width_given,
  output logic [fsp_pkg::FIELD_W-1:0]       out_width_value,
  output logic                              out_prec_given,
  output logic [fsp_pkg::FIELD_W-1:0]       out_prec_value,
  output logic [fsp_pkg::LEN_W-1:0]         out_length_count,
  output logic [fsp_pkg::CHAR_W-1:0]        out_type_char
);

  logic                       advance;
  logic                       hold_valid;
  logic [fsp_pkg::CHAR_W-1:0] hold_char;
  fsp_pkg::char_class_t       cls;
  fsp_pkg::spec_t             spec;

  // Input register.
  fsp_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_char_in (in_char_in),
    .advance    (advance),
    .hold_valid (hold_valid),
    .hold_char  (hold_char)
  );

  // Character class decode of the held item.
  fsp_char_class u_char_class (
    .char_in (hold_char),
    .cls     (cls)
  );

  // Parser state and result register.
  fsp_parse_core #(
    .NUM_BITS   (NUM_BITS),
    .MAX_LENGTH (MAX_LENGTH)
  ) u_parse_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .hold_valid (hold_valid),
    .hold_char  (hold_char),
    .cls        (cls),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_spec   (spec)
  );

  // Result fields onto their ports.
  assign out_flag_left    = spec.flags[fsp_pkg::FLAG_LEFT];
  assign out_flag_zero    = spec.flags[fsp_pkg::FLAG_ZERO];
  assign out_flag_alt     = spec.flags[fsp_pkg::FLAG_ALT];
  assign out_flag_space   = spec.flags[fsp_pkg::FLAG_SPACE];
  assign out_flag_plus    = spec.flags[fsp_pkg::FLAG_PLUS];
  assign out_width_given  = spec.width_given;
  assign out_width_value  = spec.width_value;
  assign out_prec_given   = spec.prec_given;
  assign out_prec_value   = spec.prec_value;
  assign out_length_count = spec.length_count;
  assign out_type_char    = spec.type_char;

endmodule

`default_nettype wire

/* tb/sv/fsp_spec_checker.sv */
// ----------------------------------------------------------------------------
// fsp_spec_checker
// Watches both channels of the conversion specification parser, keeps its
// own copy of the parser state to work out each decoded specification, and
// compares every result item field by field with the oldest expected one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fsp_spec_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [fsp_pkg::CHAR_W-1:0]    in_char_in,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          out_flag_left,
  input  logic                          out_flag_zero,
  input  logic                          out_flag_alt,
  input  logic                          out_flag_space,
  input  logic                          out_flag_plus,
  input  logic                          out_width_given,
  input  logic [fsp_pkg::FIELD_W-1:0]   out_width_value,
  input  logic                          out_prec_given,
  input  logic [fsp_pkg::FIELD_W-1:0]   out_prec_value,
  input  logic [fsp_pkg::LEN_W-1:0]     out_length_count,
  input  logic [fsp_pkg::CHAR_W-1:0]    out_type_char,
  output int                            error_count,
  output int                            pending_count
);
  import fsp_pkg::*;

  // Width and precision stop growing at the largest accumulator value.
  localparam int ACC_MAX = (1 << NUM_BITS_DEF) - 1;

  // Shadow copy of the parser state.
  phase_t                pst_phase;
  logic [FLAG_COUNT-1:0] pst_flags;
  int                    pst_width;
  logic                  pst_width_seen;
  int                    pst_prec;
  logic                  pst_prec_seen;
  int                    pst_length;

  // Specifications decoded but not yet seen on the result channel.
  spec_t spec_q[$];
  spec_t want;

  initial begin
    error_count   = 0;
    pending_count = 0;
  end

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [FIELD_W-1:0] got,
                             input logic [FIELD_W-1:0] exp_v);
    if (got !== exp_v) begin
      report($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, exp_v));
    end
  endtask

  task automatic clear_parser();
    pst_phase      = PH_FLAG;
    pst_flags      = '0;
    pst_width      = 0;
    pst_width_seen = 1'b0;
    pst_prec       = 0;
    pst_prec_seen  = 1'b0;
    pst_length     = 0;
  endtask

  // One decimal digit into a saturating accumulator.
  function automatic int sat_digit(input int acc, input int dval);
    int nxt;
    nxt = acc * 10 + dval;
    return (nxt > ACC_MAX) ? ACC_MAX : nxt;
  endfunction

  // Feed one character through the shadow parser; a closing character
  // queues the finished specification and starts a fresh one.
  task automatic advance_parser(input logic [CHAR_W-1:0] c);
    int    fpos;
    logic  is_digit;
    int    dval;
    spec_t spec;
    case (c)
      CH_MINUS: fpos = FLAG_LEFT;
      CH_ZERO:  fpos = FLAG_ZERO;
      CH_HASH:  fpos = FLAG_ALT;
      CH_SPACE: fpos = FLAG_SPACE;
      CH_PLUS:  fpos = FLAG_PLUS;
      default:  fpos = -1;
    endcase
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    dval     = int'(c) - int'(CH_ZERO);

    if (pst_phase == PH_FLAG && fpos >= 0) begin
      pst_flags[fpos] = 1'b1;
    end else if (is_digit && (pst_phase == PH_FLAG || pst_phase == PH_WIDTH)) begin
      pst_width      = sat_digit(pst_width, dval);
      pst_width_seen = 1'b1;
      pst_phase      = PH_WIDTH;
    end else if (c == CH_DOT && (pst_phase == PH_FLAG || pst_phase == PH_WIDTH)) begin
      pst_prec_seen = 1'b1;
      pst_prec      = 0;
      pst_phase     = PH_PREC;
    end else if (is_digit && pst_phase == PH_PREC) begin
      pst_prec = sat_digit(pst_prec, dval);
    end else if (c == CH_ELL && pst_length < MAX_LENGTH_DEF) begin
      pst_length++;
      pst_phase = PH_LEN;
    end else begin
      spec.flags        = pst_flags;
      spec.width_given  = pst_width_seen;
      spec.width_value  = pst_width[FIELD_W-1:0];
      spec.prec_given   = pst_prec_seen;
      spec.prec_value   = pst_prec[FIELD_W-1:0];
      spec.length_count = pst_length[LEN_W-1:0];
      spec.type_char    = c;
      spec_q.push_back(spec);
      clear_parser();
    end
  endtask

  // Results are compared before new characters are predicted; a result can
  // never belong to a character taken at the same edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parser();
      spec_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (spec_q.size() == 0) begin
          report($sformatf("result with type 0x%02h while none was expected",
                           out_type_char));
        end else begin
          want = spec_q.pop_front();
          check_field("flag_left", out_flag_left, want.flags[FLAG_LEFT]);
          check_field("flag_zero", out_flag_zero, want.flags[FLAG_ZERO]);
          check_field("flag_alt", out_flag_alt, want.flags[FLAG_ALT]);
          check_field("flag_space", out_flag_space, want.flags[FLAG_SPACE]);
          check_field("flag_plus", out_flag_plus, want.flags[FLAG_PLUS]);
          check_field("width_given", out_width_given, want.width_given);
          check_field("width_value", out_width_value, want.width_value);
          check_field("prec_given", out_prec_given, want.prec_given);
          check_field("prec_value", out_prec_value, want.prec_value);
          check_field("length_count", out_length_count, want.length_count);
          check_field("type_char", out_type_char, want.type_char);
        end
      end
      if (in_valid && !in_stall) begin
        advance_parser(in_char_in);
      end
    end
    pending_count <= spec_q.size();
  end

endmodule

/* tb/sv/tb_format_spec_parser_unit.sv */
// ----------------------------------------------------------------------------
// tb_format_spec_parser_unit
// Drives character streams into the conversion specification parser: a short
// directed sequence over flags, saturation and length corner cases, then
// random specifications under changing idle and stall patterns, including a
// long receiver hold that backs the parser up. The checker does the compare.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_format_spec_parser_unit;
  import fsp_pkg::*;

  // Longest forced receiver hold, and the cycle count without any accepted
  // item that ends the run; the limit is several times the hold.
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int DRAIN_CYCLES     = 8;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [CHAR_W-1:0]     in_char_in;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_flag_left;
  logic                  out_flag_zero;
  logic                  out_flag_alt;
  logic                  out_flag_space;
  logic                  out_flag_plus;
  logic                  out_width_given;
  logic [FIELD_W-1:0]    out_width_value;
  logic                  out_prec_given;
  logic [FIELD_W-1:0]    out_prec_value;
  logic [LEN_W-1:0]      out_length_count;
  logic [CHAR_W-1:0]     out_type_char;

  int error_count;
  int pending_count;
  int send_idle_pct;
  int recv_stall_pct;
  bit long_hold_req;
  int quiet_cycles;

  always #5 clk = ~clk;

  format_spec_parser_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_in       (in_char_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_flag_left    (out_flag_left),
    .out_flag_zero    (out_flag_zero),
    .out_flag_alt     (out_flag_alt),
    .out_flag_space   (out_flag_space),
    .out_flag_plus    (out_flag_plus),
    .out_width_given  (out_width_given),
    .out_width_value  (out_width_value),
    .out_prec_given   (out_prec_given),
    .out_prec_value   (out_prec_value),
    .out_length_count (out_length_count),
    .out_type_char    (out_type_char)
  );

  fsp_spec_checker spec_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_in       (in_char_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_flag_left    (out_flag_left),
    .out_flag_zero    (out_flag_zero),
    .out_flag_alt     (out_flag_alt),
    .out_flag_space   (out_flag_space),
    .out_flag_plus    (out_flag_plus),
    .out_width_given  (out_width_given),
    .out_width_value  (out_width_value),
    .out_prec_given   (out_prec_given),
    .out_prec_value   (out_prec_value),
    .out_length_count (out_length_count),
    .out_type_char    (out_type_char),
    .error_count      (error_count),
    .pending_count    (pending_count)
  );

  // Receiver: random stalls, or one long hold on request, counted here.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold_req = 1'b0;
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: too long without any item moving on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one character, possibly after some idle cycles, and return at the
  // edge that takes it.
  task automatic send_char(input logic [CHAR_W-1:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_char_in <= c;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop sending and wait until every expected result has come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending_count == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly well-formed specifications with random content; the rest are
  // bursts of random bytes or specifications with a stray character.
  task automatic run_random(input int n_chars);
    logic [CHAR_W-1:0] seq[$];
    string conv_chars;
    int sent;
    int sel;
    int nd;
    int pos;
    conv_chars = "diouxXcspfeEgGaAn%";
    sent = 0;
    while (sent < n_chars) begin
      seq.delete();
      sel = $urandom_range(99);
      if (sel < 12) begin
        repeat ($urandom_range(1, 4)) seq.push_back($urandom_range(255));
      end else begin
        // Flags, repeats allowed.
        repeat ($urandom_range(0, 3)) begin
          case ($urandom_range(FLAG_COUNT - 1))
            FLAG_LEFT:  seq.push_back(CH_MINUS);
            FLAG_ZERO:  seq.push_back(CH_ZERO);
            FLAG_ALT:   seq.push_back(CH_HASH);
            FLAG_SPACE: seq.push_back(CH_SPACE);
            default:    seq.push_back(CH_PLUS);
          endcase
        end
        // Width; now and then long enough to saturate.
        if ($urandom_range(1)) begin
          nd = ($urandom_range(9) == 0) ? $urandom_range(5, 6) : $urandom_range(1, 3);
          seq.push_back(CH_ZERO + $urandom_range(1, 9));
          repeat (nd - 1) seq.push_back(CH_ZERO + $urandom_range(9));
        end
        // Precision, possibly with no digits.
        if ($urandom_range(2) == 0) begin
          seq.push_back(CH_DOT);
          nd = ($urandom_range(9) == 0) ? $urandom_range(5, 6) : $urandom_range(0, 3);
          repeat (nd) seq.push_back(CH_ZERO + $urandom_range(9));
        end
        repeat ($urandom_range(0, 3)) seq.push_back(CH_ELL);
        if ($urandom_range(9) == 0) begin
          seq.push_back($urandom_range(255));
        end else begin
          seq.push_back(conv_chars[$urandom_range(conv_chars.len() - 1)]);
        end
        // A stray printable character somewhere breaks the structure.
        if (sel < 20) begin
          pos = $urandom_range(seq.size() - 1);
          seq.insert(pos, $urandom_range(32, 126));
        end
      end
      foreach (seq[i]) send_char(seq[i]);
      sent += seq.size();
    end
  endtask

  // Directed corner cases: all flags with a repeat, zero as a width digit,
  // dot without digits, third 'l', saturated width and precision, a flag out
  // of place, a digit after a length modifier, and the extreme byte values.
  logic [CHAR_W-1:0] directed_chars[$] = '{
    CH_MINUS, CH_SPACE, CH_ZERO, CH_HASH, CH_PLUS, CH_PLUS,
    CH_ZERO + 8'd1, CH_ZERO, CH_DOT, CH_ELL, CH_ELL, CH_ELL,
    CH_ZERO + 8'd7, CH_ZERO, CH_ZERO, CH_ZERO, CH_ZERO,
    CH_DOT, CH_NINE, CH_NINE, CH_NINE, CH_NINE, CH_NINE, CH_MINUS,
    8'h00, CH_ELL, CH_ZERO + 8'd5, 8'hFF
  };

  // Stimulus and verdict.
  initial begin
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_char_in     <= '0;
    send_idle_pct  = 8;
    recv_stall_pct = 76;
    long_hold_req  = 1'b0;
    quiet_cycles   = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_chars[i]) send_char(directed_chars[i]);
    run_random(600);
    drain_results();

    send_idle_pct  = 76;
    recv_stall_pct = 8;
    run_random(600);
    drain_results();

    // No idling, and the receiver first holds off long enough for the
    // parser to fill up and stall its input.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    long_hold_req  = 1'b1;
    run_random(650);
    drain_results();

    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
